### rtl/prc_pkg.sv
// Shared types for the polyline rectangle clipper.
// Used by polyline_rect_clipper_unit and its bench; no other dependencies.
`default_nettype none

package prc_pkg;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_ONE  = 7'b0000010,
      S_BOTH = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_FIX  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   // what the previous point was
   typedef enum logic [1:0] {
      M_IN     = 2'd0,
      M_ABSENT = 2'd1,
      M_OUT    = 2'd2
   } mode_type;

   // which edge-crossing division is running
   typedef enum logic [1:0] {
      PH_ONE_A  = 2'd0,
      PH_ONE_B  = 2'd1,
      PH_BOTH_A = 2'd2,
      PH_BOTH_B = 2'd3
   } phase_type;

   // pen commands
   localparam logic CMD_MOVE   = 1'b0;
   localparam logic CMD_VECTOR = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_RIGHT  = 2'd1;
   localparam logic [1:0] REG_BOTTOM = 2'd2;
   localparam logic [1:0] REG_TOP    = 2'd3;

endpackage

`default_nettype wire

### rtl/polyline_rect_clipper_unit.sv
// Polyline rectangle clipper: turns polyline points into clipped pen commands.
// Depends on prc_pkg for state, mode and phase types and command codes.
//
// Usage:
//   req_*  : one beat per point. tdata = {point_y, point_x}, tuser[0] = point
//            missing, tuser[1] = curve start.
//   rsp_*  : zero, one or two beats per point. tdata = {out_y, out_x},
//            tuser[0] = command (0 move, 1 vector), tlast on the final beat
//            that a point produces.
//   csr_*  : write-only clip edges: 0 left, 1 right, 2 bottom, 3 top.
// Sequencing: one point at a time. A point needing no division goes from idle,
//   perhaps through S_ONE or S_BOTH, on to its output beats, if any. Each division
//   runs a multiply state, 2*COORD_BITS+2 restoring steps and a fix-up state on
//   the shared unit. A point needs up to four divisions.
//   req_tready is high only while the sequencer is idle.
// Reset: edges go to 0/1023/0/767, the previous point becomes absent.
// Stall: results wait in a two-entry buffer while rsp_tready is low; no
//   further point is taken until the last beat is delivered.
`default_nettype none

module polyline_rect_clipper_unit
   import prc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // point beats
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,  // point_x, point_y, pad
   input  wire logic [1:0]                             req_tuser,  // point_missing, curve_start
   // command beats
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]           rsp_tdata,  // out_x, out_y, pad
   output logic [0:0]                                  rsp_tuser,  // command
   output logic                                        rsp_tlast,
   // register writes
   input  wire logic                                   csr_wen,
   input  wire logic [1:0]                             csr_index,
   input  wire logic [COORD_BITS-1:0]                  csr_wdata
);

   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;            // coordinate differences
   localparam int MW = 2 * C + 2;        // product / quotient magnitude
   localparam int SW = MW + 2;           // signed crossing result
   localparam int CW = $clog2(MW);
   localparam int TW = ((2 * C + 7) / 8) * 8;
   localparam logic [MW-1:0] QLIM = MW'(64'd1 << 40);

   typedef logic signed [C-1:0]  crd_type;
   typedef logic signed [DW-1:0] dif_type;
   typedef logic signed [SW-1:0] wid_type;

   // clamp up to lo, then down to hi
   function automatic crd_type clampc(input crd_type v, input crd_type lo, input crd_type hi);
      crd_type t;
      t = (v >= lo) ? v : lo;
      return (t <= hi) ? t : hi;
   endfunction

   // true when clamping leaves v unchanged (also for an empty range)
   function automatic logic in_range(input wid_type v, input crd_type lo, input crd_type hi);
      wid_type wl;
      wid_type wh;
      wl = SW'(lo);
      wh = SW'(hi);
      return ((v >= wl) && (v <= wh)) || ((lo > hi) && (v == wh));
   endfunction

   // registers
   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   mode_type       mode_ff, mode_in;
   crd_type        left_ff, left_in, right_ff, right_in;
   crd_type        bottom_ff, bottom_in, top_ff, top_in;
   crd_type        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   crd_type        ix_ff, ix_in, iy_ff, iy_in, ox_ff, ox_in, oy_ff, oy_in;
   crd_type        ax_ff, ax_in, ay_ff, ay_in;
   dif_type        dx_ff, dx_in, dy_ff, dy_in;
   dif_type        a_ff, a_in, b_ff, b_in, c_ff, c_in;
   crd_type        base_ff, base_in;
   logic [MW-1:0]  prod_ff, prod_in;
   logic [DW-1:0]  rem_ff, rem_in, uc_ff, uc_in;
   logic           neg_ff, neg_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           bufc_ff [2];
   logic           bufc_in [2];
   crd_type        bufx_ff [2];
   crd_type        bufx_in [2];
   crd_type        bufy_ff [2];
   crd_type        bufy_in [2];
   logic [1:0]     n_ff, n_in;
   logic           rd_ff, rd_in;
   logic           dest_ff, dest_in;

   // next-state logic
   always_comb begin
      crd_type       px, py, ex1, ey1, ex2, ey2, eg;
      mode_type      mv;
      logic          pin;
      dif_type       ddx, ddy;
      logic [DW-1:0] ua, ub;
      logic [DW:0]   tr, ucx;
      logic          ge;
      logic [MW-1:0] qmag;
      wid_type       qs, v;

      state_in  = state_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      top_in    = top_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      ix_in = ix_ff;  iy_in = iy_ff;  ox_in = ox_ff;  oy_in = oy_ff;
      ax_in = ax_ff;  ay_in = ay_ff;
      dx_in = dx_ff;  dy_in = dy_ff;
      a_in  = a_ff;   b_in  = b_ff;   c_in  = c_ff;   base_in = base_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      uc_in   = uc_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      bufc_in = bufc_ff;
      bufx_in = bufx_ff;
      bufy_in = bufy_ff;
      n_in    = n_ff;
      rd_in   = rd_ff;
      dest_in = dest_ff;

      px  = crd_type'(req_tdata[C-1:0]);
      py  = crd_type'(req_tdata[2*C-1:C]);
      mv  = req_tuser[1] ? M_ABSENT : mode_ff;
      pin = in_range(SW'(px), left_ff, right_ff) && in_range(SW'(py), bottom_ff, top_ff);
      ex1 = clampc(ax_ff, left_ff, right_ff);
      ey1 = clampc(ay_ff, bottom_ff, top_ff);
      ex2 = clampc(ox_ff, left_ff, right_ff);
      ey2 = clampc(oy_ff, bottom_ff, top_ff);
      ddx = '0;
      ddy = '0;
      eg  = '0;
      ua  = a_ff[DW-1] ? DW'(-a_ff) : DW'(a_ff);
      ub  = b_ff[DW-1] ? DW'(-b_ff) : DW'(b_ff);
      tr  = {rem_ff, prod_ff[MW-1]};
      ucx = {1'b0, uc_ff};
      ge  = (tr >= ucx);
      if (uc_ff == '0)
         qmag = '0;
      else if ((MW > 41) && (prod_ff > QLIM))
         qmag = QLIM;
      else
         qmag = prod_ff;
      qs = neg_ff ? -wid_type'(SW'(qmag)) : wid_type'(SW'(qmag));
      v  = wid_type'(SW'(base_ff)) + qs;

      // configuration writes
      if (csr_wen) begin
         unique case (csr_index)
            REG_LEFT:   left_in   = crd_type'(csr_wdata);
            REG_RIGHT:  right_in  = crd_type'(csr_wdata);
            REG_BOTTOM: bottom_in = crd_type'(csr_wdata);
            REG_TOP:    top_in    = crd_type'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         // take a point and pick the case
         S_IDLE: begin
            if (req_tvalid) begin
               rd_in = 1'b0;
               if (req_tuser[0]) begin
                  mode_in = M_ABSENT;
               end else begin
                  prev_x_in = px;
                  prev_y_in = py;
                  if (pin) begin
                     mode_in = M_IN;
                     unique case (mv)
                        M_ABSENT: begin
                           bufc_in[0] = CMD_MOVE; bufx_in[0] = px; bufy_in[0] = py;
                           n_in = 2'd1;
                           state_in = S_OUT;
                        end
                        M_IN: begin
                           bufc_in[0] = CMD_MOVE; bufx_in[0] = prev_x_ff;
                           bufy_in[0] = prev_y_ff;
                           bufc_in[1] = CMD_VECTOR; bufx_in[1] = px; bufy_in[1] = py;
                           n_in = 2'd2;
                           state_in = S_OUT;
                        end
                        M_OUT: begin
                           ix_in = px; iy_in = py; ox_in = prev_x_ff; oy_in = prev_y_ff;
                           dest_in = 1'b0;
                           bufc_in[0] = CMD_MOVE;
                           bufc_in[1] = CMD_VECTOR; bufx_in[1] = px; bufy_in[1] = py;
                           n_in = 2'd2;
                           state_in = S_ONE;
                        end
                        default: ;
                     endcase
                  end else begin
                     mode_in = M_OUT;
                     unique case (mv)
                        M_IN: begin
                           ix_in = prev_x_ff; iy_in = prev_y_ff; ox_in = px; oy_in = py;
                           dest_in = 1'b0;
                           bufc_in[0] = CMD_VECTOR;
                           n_in = 2'd1;
                           state_in = S_ONE;
                        end
                        M_OUT: begin
                           ax_in = prev_x_ff; ay_in = prev_y_ff; ox_in = px; oy_in = py;
                           bufc_in[0] = CMD_MOVE;
                           bufc_in[1] = CMD_VECTOR;
                           n_in = 2'd2;
                           state_in = S_BOTH;
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end

         // pull the outer point onto the frame
         S_ONE: begin
            ddx = DW'(ox_ff) - DW'(ix_ff);
            ddy = DW'(oy_ff) - DW'(iy_ff);
            dx_in = ddx;
            dy_in = ddy;
            if ((ddx == '0) || (ddy == '0)) begin
               bufx_in[dest_ff] = ex2;
               bufy_in[dest_ff] = ey2;
               state_in = S_OUT;
            end else begin
               eg = ddx[DW-1] ? left_ff : right_ff;
               bufx_in[dest_ff] = eg;
               a_in = ddy;
               b_in = DW'(eg) - DW'(ix_ff);
               c_in = ddx;
               base_in  = iy_ff;
               phase_in = PH_ONE_A;
               state_in = S_MUL;
            end
         end

         // segment between two outside points
         S_BOTH: begin
            ddx = DW'(ox_ff) - DW'(ax_ff);
            ddy = DW'(oy_ff) - DW'(ay_ff);
            dx_in = ddx;
            dy_in = ddy;
            if (ddx == '0) begin
               if ((ax_ff != ex1) || (ey1 == ey2)) begin
                  state_in = S_IDLE;
               end else begin
                  bufx_in[0] = ax_ff; bufy_in[0] = ey1;
                  bufx_in[1] = ox_ff; bufy_in[1] = ey2;
                  state_in = S_OUT;
               end
            end else if (ddy == '0) begin
               if ((ay_ff != ey1) || (ex1 == ex2)) begin
                  state_in = S_IDLE;
               end else begin
                  bufx_in[0] = ex1; bufy_in[0] = ay_ff;
                  bufx_in[1] = ex2; bufy_in[1] = oy_ff;
                  state_in = S_OUT;
               end
            end else if ((ex1 == ex2) || (ey1 == ey2)) begin
               state_in = S_IDLE;
            end else begin
               bufx_in[0] = ex1;
               a_in = ddy;
               b_in = DW'(ex1) - DW'(ax_ff);
               c_in = ddx;
               base_in  = ay_ff;
               phase_in = PH_BOTH_A;
               state_in = S_MUL;
            end
         end

         // magnitudes and product
         S_MUL: begin
            prod_in = MW'(ua) * MW'(ub);
            uc_in   = c_ff[DW-1] ? DW'(-c_ff) : DW'(c_ff);
            neg_in  = a_ff[DW-1] ^ b_ff[DW-1] ^ c_ff[DW-1];
            rem_in  = '0;
            cnt_in  = '0;
            state_in = S_DIV;
         end

         // restoring divide, one quotient bit a cycle
         S_DIV: begin
            rem_in  = ge ? DW'(tr - ucx) : DW'(tr);
            prod_in = {prod_ff[MW-2:0], ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1))
               state_in = S_FIX;
         end

         // apply the signed quotient and continue
         S_FIX: begin
            unique case (phase_ff)
               PH_ONE_A: begin
                  if (in_range(v, bottom_ff, top_ff)) begin
                     bufy_in[dest_ff] = v[C-1:0];
                     state_in = S_OUT;
                  end else begin
                     eg = dy_ff[DW-1] ? bottom_ff : top_ff;
                     bufy_in[dest_ff] = eg;
                     a_in = DW'(eg) - DW'(iy_ff);
                     b_in = dx_ff;
                     c_in = dy_ff;
                     base_in  = ix_ff;
                     phase_in = PH_ONE_B;
                     state_in = S_MUL;
                  end
               end
               PH_ONE_B: begin
                  bufx_in[dest_ff] = v[C-1:0];
                  state_in = S_OUT;
               end
               PH_BOTH_A: begin
                  if (in_range(v, bottom_ff, top_ff)) begin
                     bufy_in[0] = v[C-1:0];
                     ix_in = bufx_ff[0];
                     iy_in = v[C-1:0];
                     dest_in  = 1'b1;
                     state_in = S_ONE;
                  end else begin
                     bufy_in[0] = ey1;
                     a_in = DW'(ey1) - DW'(ay_ff);
                     b_in = dx_ff;
                     c_in = dy_ff;
                     base_in  = ax_ff;
                     phase_in = PH_BOTH_B;
                     state_in = S_MUL;
                  end
               end
               PH_BOTH_B: begin
                  if (!in_range(v, left_ff, right_ff)) begin
                     state_in = S_IDLE;
                  end else begin
                     bufx_in[0] = v[C-1:0];
                     ix_in = v[C-1:0];
                     iy_in = bufy_ff[0];
                     dest_in  = 1'b1;
                     state_in = S_ONE;
                  end
               end
               default: ;
            endcase
         end

         // hand out the buffered beats
         S_OUT: begin
            if (rsp_tready) begin
               if (rsp_tlast)
                  state_in = S_IDLE;
               else
                  rd_in = 1'b1;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = TW'({bufy_ff[rd_ff], bufx_ff[rd_ff]});
   assign rsp_tuser  = bufc_ff[rd_ff];
   assign rsp_tlast  = (n_ff == 2'd1) || rd_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= M_ABSENT;
         left_ff   <= '0;
         right_ff  <= C'(1023);
         bottom_ff <= '0;
         top_ff    <= C'(767);
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         rd_ff     <= 1'b0;
         n_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         rd_ff     <= rd_in;
         n_ff      <= n_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      ix_ff    <= ix_in;
      iy_ff    <= iy_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      base_ff  <= base_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      uc_ff    <= uc_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      bufc_ff  <= bufc_in;
      bufx_ff  <= bufx_in;
      bufy_ff  <= bufy_in;
      dest_ff  <= dest_in;
   end

endmodule

`default_nettype wire

### sim/tb_polyline_rect_clipper_unit.sv
// Self-checking bench for polyline_rect_clipper_unit: drives points, edge writes and
// random stalls, and checks every command beat against an in-bench clipping predictor.
// Depends on prc_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_polyline_rect_clipper_unit
   import prc_pkg::*;
();

   localparam int CB = 16;
   localparam longint QUOT_SAT = 64'sd1 << 40;

   typedef struct {
      logic            cmd;
      logic [CB-1:0]   x;
      logic [CB-1:0]   y;
      logic            last;
   } cmd_beat_type;

   // Clipping predictor plus queue of command beats still owed by the block
   class clip_scoreboard;
      longint lft, rgt, bot, tp;
      mode_type mode;
      longint px, py;
      cmd_beat_type owed[$];
      cmd_beat_type fresh[$];
      int errors, beats, points;

      function new();
         lft = 0; rgt = 1023; bot = 0; tp = 767;
         mode = M_ABSENT; px = 0; py = 0;
         errors = 0; beats = 0; points = 0;
      endfunction

      function void set_edge(logic [1:0] idx, logic [CB-1:0] v);
         longint s;
         s = longint'($signed(v));
         case (idx)
            REG_LEFT:   lft = s;
            REG_RIGHT:  rgt = s;
            REG_BOTTOM: bot = s;
            REG_TOP:    tp = s;
         endcase
      endfunction

      function longint clamp_x(longint v);
         longint t;
         t = (v >= lft) ? v : lft;
         return (t <= rgt) ? t : rgt;
      endfunction

      function longint clamp_y(longint v);
         longint t;
         t = (v >= bot) ? v : bot;
         return (t <= tp) ? t : tp;
      endfunction

      // trunc(a*b/c), exact, saturated at +-2^40
      function longint scale_div(longint a, longint b, longint c);
         bit [127:0] p, q;
         longint unsigned ua, ub, uc;
         bit neg;
         if (c == 0) return 0;
         ua = (a < 0) ? -a : a;
         ub = (b < 0) ? -b : b;
         uc = (c < 0) ? -c : c;
         neg = ((a < 0) != (b < 0)) != (c < 0);
         p = {64'd0, ua} * {64'd0, ub};
         q = p / {64'd0, uc};
         if (q > 128'(QUOT_SAT)) q = 128'(QUOT_SAT);
         return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
      endfunction

      // move (ox,oy) onto the frame along the line from (ix,iy)
      function void cut_one(longint ix, longint iy, inout longint ox, inout longint oy);
         longint dx, dy, ex, ey;
         dx = ox - ix; dy = oy - iy;
         ex = clamp_x(ox); ey = clamp_y(oy);
         if (dx != 0 && dy != 0) begin
            ex = (dx > 0) ? rgt : lft;
            ey = iy + scale_div(dy, ex - ix, dx);
            if (clamp_y(ey) != ey) begin
               ey = (dy > 0) ? tp : bot;
               ex = ix + scale_div(ey - iy, dx, dy);
            end
         end
         ox = ex; oy = ey;
      endfunction

      // visible piece between two outside points; 0 if it misses the frame
      function bit cut_both(inout longint x1, inout longint y1,
                            inout longint x2, inout longint y2);
         longint ex1, ey1, ex2, ey2, dx, dy, tx, ty;
         ex1 = clamp_x(x1); ey1 = clamp_y(y1);
         ex2 = clamp_x(x2); ey2 = clamp_y(y2);
         dx = x2 - x1; dy = y2 - y1;
         if (dx == 0) begin
            if (x1 != ex1 || ey1 == ey2) return 0;
            y1 = ey1; y2 = ey2;
         end else if (dy == 0) begin
            if (y1 != ey1 || ex1 == ex2) return 0;
            x1 = ex1; x2 = ex2;
         end else begin
            if (ex1 == ex2 || ey1 == ey2) return 0;
            tx = ex1;
            ty = y1 + scale_div(dy, tx - x1, dx);
            if (ty != clamp_y(ty)) begin
               ty = ey1;
               tx = x1 + scale_div(ty - y1, dx, dy);
               if (tx != clamp_x(tx)) return 0;
            end
            x1 = tx; y1 = ty;
            cut_one(tx, ty, x2, y2);
         end
         return 1;
      endfunction

      function void add(logic cmd, longint x, longint y);
         cmd_beat_type b;
         b.cmd = cmd; b.x = x[CB-1:0]; b.y = y[CB-1:0]; b.last = 1'b0;
         fresh.push_back(b);
      endfunction

      // accepted point: predict its command beats
      function void note_point(logic [CB-1:0] xi, logic [CB-1:0] yi, bit miss, bit start);
         longint x, y, ax, ay, bx, by;
         x = longint'($signed(xi));
         y = longint'($signed(yi));
         fresh.delete();
         points++;
         if (start) mode = M_ABSENT;
         if (miss) begin
            mode = M_ABSENT;
            return;
         end
         if (x == clamp_x(x) && y == clamp_y(y)) begin
            if (mode == M_ABSENT) add(CMD_MOVE, x, y);
            else begin
               ax = px; ay = py;
               if (mode == M_OUT) cut_one(x, y, ax, ay);
               add(CMD_MOVE, ax, ay);
               add(CMD_VECTOR, x, y);
            end
            mode = M_IN;
         end else begin
            bx = x; by = y;
            if (mode == M_IN) begin
               cut_one(px, py, bx, by);
               add(CMD_VECTOR, bx, by);
            end else if (mode == M_OUT) begin
               ax = px; ay = py;
               if (cut_both(ax, ay, bx, by)) begin
                  add(CMD_MOVE, ax, ay);
                  add(CMD_VECTOR, bx, by);
               end
            end
            mode = M_OUT;
         end
         px = x; py = y;
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         foreach (fresh[i]) owed.push_back(fresh[i]);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_beat(logic cmd, logic [CB-1:0] x, logic [CB-1:0] y, logic last);
         cmd_beat_type e;
         beats++;
         if (owed.size() == 0) begin
            report($sformatf("unexpected beat cmd=%0b x=%0d y=%0d", cmd, $signed(x),
                             $signed(y)));
            return;
         end
         e = owed.pop_front();
         if (cmd !== e.cmd) report($sformatf("command %0b, want %0b", cmd, e.cmd));
         if (x !== e.x) report($sformatf("x %0d, want %0d", $signed(x), $signed(e.x)));
         if (y !== e.y) report($sformatf("y %0d, want %0d", $signed(y), $signed(e.y)));
         if (last !== e.last) report($sformatf("tlast %0b, want %0b", last, e.last));
      endtask
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wen;
   logic [1:0] csr_index;
   logic [CB-1:0] csr_wdata;

   clip_scoreboard sb;
   bit idle_ok;
   bit hold_req;
   int edge_writes;

   polyline_rect_clipper_unit #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // run limit
   initial begin
      #3000000;
      $display("Timeout: block stopped making progress");
      $display("*** FAILED ***");
      $finish;
   end

   // result monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tuser[0], rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n - 1) @(negedge clock);
         end else
            rsp_tready <= 1'b1;
      end
   end

   // one point beat; entered and left just after a falling edge
   task send_point(logic [CB-1:0] x, logic [CB-1:0] y, bit miss, bit start);
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      req_tuser <= {start, miss};
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y, miss, start);
      @(negedge clock);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   // wait for all owed beats, then let any silent point finish
   task drain();
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // write enable stays high across back-to-back writes; set_rect drops it
   task write_edge(logic [1:0] idx, logic [CB-1:0] v);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      sb.set_edge(idx, v);
      edge_writes++;
   endtask

   task set_rect(longint l, longint r, longint b, longint t);
      drain();
      write_edge(REG_LEFT, l[CB-1:0]);
      write_edge(REG_RIGHT, r[CB-1:0]);
      write_edge(REG_BOTTOM, b[CB-1:0]);
      write_edge(REG_TOP, t[CB-1:0]);
      csr_wen <= 1'b0;
   endtask

   // coordinate biased toward the window around [lo..hi]
   function logic [CB-1:0] pick_coord(longint lo, longint hi);
      longint a, b, span, wl, wh;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      span = b - a + 8;
      wl = a - span / 4; wh = b + span / 4;
      if (wl < -32768) wl = -32768;
      if (wh > 32767) wh = 32767;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return CB'(wl + longint'($urandom_range(0, int'(wh - wl))));
         6: return CB'(a + longint'($urandom_range(0, 2)) - 1);
         7: return CB'(b + longint'($urandom_range(0, 2)) - 1);
         default: return CB'($urandom);
      endcase
   endfunction

   task random_points(int count, int ph);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) idle_ok = (ph < 4) && ($urandom_range(0, 3) != 0);
         if (ph == 1 && i == 20) hold_req = 1;
         if (ph == 2 && i == 60) drain();
         send_point(pick_coord(sb.lft, sb.rgt), pick_coord(sb.bot, sb.tp),
                    $urandom_range(0, 19) == 0, $urandom_range(0, 11) == 0);
      end
   endtask

   initial begin
      sb = new();
      edge_writes = 0;
      idle_ok = 0;
      hold_req = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_wen = 1'b0; csr_index = REG_LEFT; csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every mode transition, straight and missed segments, extremes
      send_point(16'sd100, 16'sd100, 0, 1);
      send_point(16'sd200, 16'sd300, 0, 0);
      send_point(16'sd2000, 16'sd300, 0, 0);
      send_point(16'sd500, -16'sd50, 0, 0);
      send_point(16'sd300, 16'sd400, 0, 0);
      send_point(16'sd300, 16'sd900, 0, 0);
      send_point(16'sd300, -16'sd100, 0, 0);
      send_point(-16'sd100, 16'sd200, 0, 0);
      send_point(16'sd1500, 16'sd200, 0, 0);
      send_point(16'sd1500, 16'sd2000, 0, 0);
      send_point(16'sd0, 16'sd0, 1, 0);
      send_point(16'h8000, 16'h8000, 0, 0);
      send_point(16'h7FFF, 16'h7FFF, 0, 0);
      send_point(16'sd0, 16'sd0, 0, 0);
      send_point(16'sd1023, 16'sd767, 0, 0);
      send_point(16'sd512, 16'sd384, 0, 1);
      send_point(16'h8000, 16'h7FFF, 0, 0);
      send_point(16'h7FFF, 16'h8000, 0, 0);
      send_point(16'sd5, 16'sd5, 1, 1);
      send_point(16'sd1023, 16'sd0, 0, 0);
      send_point(16'hFFFF, 16'hFFFF, 0, 0);
      random_points(140, 0);

      set_rect(-32768, 32767, -32768, 32767);
      random_points(140, 1);
      set_rect(-20, 20, -10, 10);
      random_points(140, 2);
      set_rect(500, -500, 300, -300);
      random_points(140, 3);
      set_rect(longint'($urandom_range(0, 2000)) - 1000, longint'($urandom_range(0, 2000)),
               longint'($urandom_range(0, 2000)) - 1000, longint'($urandom_range(0, 2000)));
      random_points(140, 4);

      idle_ok = 0;
      drain();
      if (sb.owed.size() != 0) sb.report("command beats never delivered");
      $display("Covered %0d points and %0d command beats over 5 clip rectangles (%0d edge writes),",
               sb.points, sb.beats, edge_writes);
      $display("including full-range, tiny and empty rectangles and a long output stall.");
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
